// ----- sv/bf5_pkg.sv -----
// Shared types, constants and helpers for the 5x5 box filter.
// No dependencies; every other file of the block uses it by scoped names.
package bf5_pkg;

  localparam int KERNEL      = 5;
  localparam int LINES       = KERNEL - 1;
  localparam int HALF_K      = KERNEL / 2;
  localparam int CHANNELS    = 3;
  localparam int ROUND       = (KERNEL * KERNEL) / 2;
  localparam int RECIP       = 5243;
  localparam int RECIP_SHIFT = 17;
  localparam int HEIGHT_CAP  = 1024;
  localparam int OUT_DEPTH   = 8;
  localparam int PTR_W       = 3;

  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [10:0] HEIGHT_RESET = 11'd480;

  localparam logic       OP_PIXEL = 1'b0;
  localparam logic       OP_FLUSH = 1'b1;

  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;

  // channel 0 blue, 1 green, 2 red
  typedef logic [CHANNELS-1:0][7:0] pix_t;

  typedef struct packed {
    logic [9:0] row;
    logic [9:0] col;
  } pos_t;

  typedef struct packed {
    pos_t pos;
    logic last;
    logic filter;
  } meta_t;

  typedef struct packed {
    pix_t pix;
    pos_t pos;
    logic last;
  } res_t;

  function automatic logic [10:0] dim_clamp(logic [10:0] v, logic [10:0] cap);
    logic [10:0] r;
    r = v;
    if (v == 11'd0) begin
      r = 11'd1;
    end else if (v > cap) begin
      r = cap;
    end
    return r;
  endfunction

  function automatic pos_t pos_advance(pos_t p, logic [10:0] w, logic [10:0] h);
    pos_t q;
    q = p;
    if ({1'b0, p.col} + 11'd1 >= w) begin
      q.col = '0;
      if ({1'b0, p.row} + 11'd1 >= h) begin
        q.row = '0;
      end else begin
        q.row = p.row + 10'd1;
      end
    end else begin
      q.col = p.col + 10'd1;
    end
    return q;
  endfunction

endpackage

// ----- sv/bf5_line_store.sv -----
// Four line buffers of the 5x5 box filter, one bank per row slot.
// Depends on bf5_pkg for the pixel type and line count.
module bf5_line_store #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [1:0]                   wr_bank,
  input  logic [$clog2(MAX_WIDTH)-1:0] addr,
  input  bf5_pkg::pix_t                wr_data,
  output bf5_pkg::pix_t                rd_data [bf5_pkg::LINES]
);

  genvar b;
  generate
    for (b = 0; b < bf5_pkg::LINES; b++) begin : g_bank
      bf5_pkg::pix_t mem [MAX_WIDTH];
      bf5_pkg::pix_t rd_r;

      always_ff @(posedge clk) begin
        if (en) begin
          rd_r <= mem[addr];
          if (wr_bank == 2'(b)) begin
            mem[addr] <= wr_data;
          end
        end
      end

      assign rd_data[b] = rd_r;
    end
  endgenerate

endmodule

// ----- sv/bf5_window_sum.sv -----
// Column sums of the 5x5 window, rounded window total (zero when filter is low) and mean by reciprocal.
// Depends on bf5_pkg for the pixel type and the rounding constants.
module bf5_window_sum (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift_en,
  input  bf5_pkg::pix_t col_pix [bf5_pkg::LINES],
  input  bf5_pkg::pix_t new_pix,
  input  logic          tot_en,
  input  logic          filter,
  output bf5_pkg::pix_t mean
);

  typedef logic [bf5_pkg::CHANNELS-1:0][10:0] csum_t;
  typedef logic [bf5_pkg::CHANNELS-1:0][12:0] tsum_t;

  csum_t colsum_r [bf5_pkg::KERNEL];
  csum_t col_nxt;
  tsum_t total_r;
  tsum_t total_nxt;
  logic [25:0] prod [bf5_pkg::CHANNELS];

  always_comb begin
    for (int c = 0; c < bf5_pkg::CHANNELS; c++) begin
      col_nxt[c] = 11'(new_pix[c]);
      for (int k = 0; k < bf5_pkg::LINES; k++) begin
        col_nxt[c] = col_nxt[c] + 11'(col_pix[k][c]);
      end
      total_nxt[c] = 13'(bf5_pkg::ROUND);
      for (int k = 0; k < bf5_pkg::KERNEL; k++) begin
        total_nxt[c] = total_nxt[c] + 13'(colsum_r[k][c]);
      end
      if (!filter) begin
        total_nxt[c] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < bf5_pkg::KERNEL; k++) begin
        colsum_r[k] <= '0;
      end
    end else if (shift_en) begin
      for (int k = 0; k < bf5_pkg::KERNEL - 1; k++) begin
        colsum_r[k] <= colsum_r[k+1];
      end
      colsum_r[bf5_pkg::KERNEL-1] <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tot_en) begin
      total_r <= total_nxt;
    end
  end

  always_comb begin
    for (int c = 0; c < bf5_pkg::CHANNELS; c++) begin
      prod[c] = 26'(total_r[c]) * 26'(bf5_pkg::RECIP);
      mean[c] = prod[c][bf5_pkg::RECIP_SHIFT +: 8];
    end
  end

endmodule

// ----- sv/bf5_out_fifo.sv -----
// Result queue between the filter pipeline and the output channel.
// Depends on bf5_pkg for the result type and queue depth.
module bf5_out_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  bf5_pkg::res_t           push_data,
  input  logic                    pop,
  output logic                    valid,
  output bf5_pkg::res_t           head,
  output logic [bf5_pkg::PTR_W:0] count
);

  bf5_pkg::res_t mem_r [bf5_pkg::OUT_DEPTH];
  logic [bf5_pkg::PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [bf5_pkg::PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [bf5_pkg::PTR_W:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + {{bf5_pkg::PTR_W{1'b0}}, push} - {{bf5_pkg::PTR_W{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign valid = count_r != '0;
  assign head  = mem_r[rd_ptr_r];
  assign count = count_r;

endmodule

// ----- sv/box_filter_5x5_rgb_unit.sv -----
// 5x5 box filter over a raster BGR stream; top level with position control.
// Path: a transaction that produces a result passes the s1, s2 and s3 stage registers and the result queue to out_*.
// Throughput: one transaction per cycle; in_stall rises only when queued results plus the
//   3 pipeline stages in flight reach the 8-entry result queue depth.
// Reset: synchronous, active low; clears positions, pending count, pipeline and queue,
//   loads 640x480. Line buffers are not cleared; there is no clearing pass.
module box_filter_5x5_rgb_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [7:0]  in_blue_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_red_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_blue_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_red_out,
  output logic [9:0]  out_row,
  output logic [9:0]  out_column,
  output logic        out_frame_last
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int WCAP   = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

  logic [10:0]   width_r, width_nxt;
  logic [10:0]   height_r, height_nxt;
  bf5_pkg::pos_t in_pos_r, in_pos_nxt;
  bf5_pkg::pos_t out_pos_r, out_pos_nxt;
  logic [11:0]   pending_r, pending_nxt;

  logic [10:0]   w_eff, h_eff;
  logic [11:0]   lag;
  logic          accept, is_pix, start, pix_emit, flush_emit, item_emit;
  bf5_pkg::pos_t out_base, emit_pos;
  logic [11:0]   pend_base, pend_inc;
  logic          interior, last;
  bf5_pkg::pix_t pix_in;

  logic          s1_valid_r, s1_emit_r, s1_is_pix_r;
  bf5_pkg::meta_t s1_meta_r, s2_meta_r, s3_meta_r;
  bf5_pkg::pix_t s1_pix_r;
  logic          s2_valid_r, s3_valid_r;

  bf5_pkg::pix_t line_rd [bf5_pkg::LINES];
  bf5_pkg::pix_t mean;
  bf5_pkg::res_t push_data, head;
  logic [bf5_pkg::PTR_W:0] q_count, used;
  logic          pop;

  assign w_eff  = bf5_pkg::dim_clamp(width_r, 11'(WCAP));
  assign h_eff  = bf5_pkg::dim_clamp(height_r, 11'(bf5_pkg::HEIGHT_CAP));
  assign lag    = {w_eff, 1'b0} + 12'(bf5_pkg::HALF_K);
  assign pix_in = {in_red_in, in_green_in, in_blue_in};

  assign used = q_count + (bf5_pkg::PTR_W+1)'(s1_valid_r) + (bf5_pkg::PTR_W+1)'(s2_valid_r)
              + (bf5_pkg::PTR_W+1)'(s3_valid_r);
  assign in_stall = used >= (bf5_pkg::PTR_W+1)'(bf5_pkg::OUT_DEPTH);
  assign accept   = in_valid && !in_stall;
  assign is_pix   = in_operation == bf5_pkg::OP_PIXEL;

  always_comb begin
    start      = in_pos_r == '0;
    out_base   = start ? '0 : out_pos_r;
    pend_base  = start ? '0 : pending_r;
    pend_inc   = pend_base + 12'd1;
    pix_emit   = pend_inc > lag;
    flush_emit = start && (pending_r != '0);
    item_emit  = is_pix ? pix_emit : flush_emit;
    emit_pos   = is_pix ? out_base : out_pos_r;
    interior   = (emit_pos.row >= 10'(bf5_pkg::HALF_K))
              && ({1'b0, emit_pos.row} + 11'(bf5_pkg::HALF_K) < h_eff)
              && (emit_pos.col >= 10'(bf5_pkg::HALF_K))
              && ({1'b0, emit_pos.col} + 11'(bf5_pkg::HALF_K) < w_eff);
    last       = ({1'b0, emit_pos.row} == h_eff - 11'd1)
              && ({1'b0, emit_pos.col} == w_eff - 11'd1);
  end

  always_comb begin
    width_nxt   = width_r;
    height_nxt  = height_r;
    in_pos_nxt  = in_pos_r;
    out_pos_nxt = out_pos_r;
    pending_nxt = pending_r;
    if (cfg_we) begin
      case (cfg_index)
        bf5_pkg::CFG_IMAGE_WIDTH: begin
          width_nxt   = cfg_wdata;
          in_pos_nxt  = '0;
          out_pos_nxt = '0;
          pending_nxt = '0;
        end
        bf5_pkg::CFG_IMAGE_HEIGHT: begin
          height_nxt  = cfg_wdata;
          in_pos_nxt  = '0;
          out_pos_nxt = '0;
          pending_nxt = '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (is_pix) begin
        in_pos_nxt = bf5_pkg::pos_advance(in_pos_r, w_eff, h_eff);
        if (pix_emit) begin
          out_pos_nxt = bf5_pkg::pos_advance(out_base, w_eff, h_eff);
          pending_nxt = pend_base;
        end else begin
          out_pos_nxt = out_base;
          pending_nxt = pend_inc;
        end
      end else if (flush_emit) begin
        out_pos_nxt = bf5_pkg::pos_advance(out_pos_r, w_eff, h_eff);
        pending_nxt = pending_r - 12'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= bf5_pkg::WIDTH_RESET;
      height_r   <= bf5_pkg::HEIGHT_RESET;
      in_pos_r   <= '0;
      out_pos_r  <= '0;
      pending_r  <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      in_pos_r   <= in_pos_nxt;
      out_pos_r  <= out_pos_nxt;
      pending_r  <= pending_nxt;
      s1_valid_r <= accept && (is_pix || flush_emit);
      s2_valid_r <= s1_valid_r && s1_emit_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit_r        <= item_emit;
      s1_is_pix_r      <= is_pix;
      s1_pix_r         <= pix_in;
      s1_meta_r.pos    <= emit_pos;
      s1_meta_r.last   <= last;
      s1_meta_r.filter <= is_pix && interior;
    end
    if (s1_valid_r) begin
      s2_meta_r <= s1_meta_r;
    end
    if (s2_valid_r) begin
      s3_meta_r <= s2_meta_r;
    end
  end

  bf5_line_store #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .en      (accept && is_pix),
    .wr_bank (in_pos_r.row[1:0]),
    .addr    (ADDR_W'(in_pos_r.col)),
    .wr_data (pix_in),
    .rd_data (line_rd)
  );

  bf5_window_sum u_window_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (s1_valid_r && s1_is_pix_r),
    .col_pix  (line_rd),
    .new_pix  (s1_pix_r),
    .tot_en   (s2_valid_r),
    .filter   (s2_meta_r.filter),
    .mean     (mean)
  );

  assign push_data.pix  = mean;
  assign push_data.pos  = s3_meta_r.pos;
  assign push_data.last = s3_meta_r.last;
  assign pop            = out_valid && !out_stall;

  bf5_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s3_valid_r),
    .push_data (push_data),
    .pop       (pop),
    .valid     (out_valid),
    .head      (head),
    .count     (q_count)
  );

  assign out_blue_out   = head.pix[0];
  assign out_green_out  = head.pix[1];
  assign out_red_out    = head.pix[2];
  assign out_row        = head.pos.row;
  assign out_column     = head.pos.col;
  assign out_frame_last = head.last;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    used <= (bf5_pkg::PTR_W+1)'(bf5_pkg::OUT_DEPTH))
    else $error("result queue overrun");

  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= lag)
    else $error("pending count beyond lag");

  a_stage_order: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r |-> $past(s1_valid_r && s1_emit_r, 2))
    else $error("result stage without emitting transaction");
`endif

endmodule
